>>> sv/tlhd_pkg.sv
// Package for the timestamped level history: field widths, codes, FSM state
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tlhd_pkg;

    // Field widths
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 22;
    localparam int OUT_W   = 17;

    // Default history depth
    localparam int DEPTH_DEFAULT = 16;

    // Reset value of the look-back window, in ms
    localparam logic [WIN_W-1:0] WINDOW_RESET = 22'd15000;

    // Distance under which the walk stops early, in ms
    localparam logic [TIME_W-1:0] NEAR_MS = 32'd1000;

    // Starting best distance: larger than any real distance
    localparam logic [TIME_W-1:0] NO_DISTANCE = 32'hFFFF_FFFF;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_RESPOND
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic push;
        logic capture;
        logic issue_read;
        logic compare;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_empty;
        logic more_left;
        logic near_hit;
    } dp_status_t;

endpackage

>>> sv/timestamped_level_history_diff.sv
// Usage guide:
// Top level of the timestamped level history. Instantiates tlhd_ctrl and
// tlhd_dp (which holds the tlhd_ram ring store); uses tlhd_pkg.
//
// A request is taken at a rising edge with start high and busy low.
// operation = push stores level_cm and time_ms at the ring head; busy stays
// low, so pushes may arrive every cycle. operation = query looks for the
// stored sample nearest to time_ms - window and returns its level minus
// level_cm. The result appears on level_change_cm with done high for
// exactly one cycle; the receiver cannot stall it. An empty history answers
// 0 in the cycle after the request. Otherwise the walk reads one entry per
// cycle through the single store port, newest first, and stops at the first
// entry within 1000 ms or after the last stored one; the controller passes
// through ST_READ, stays in ST_WALK while the k entries (1..DEPTH) are read,
// then raises done in ST_RESPOND, and busy falls the cycle after done.
// The window register is written through cfg_valid/cfg_ready, ready while
// not busy. Reset empties the history and sets the window to 15000 ms.
`timescale 1ns / 1ps

module timestamped_level_history_diff #(
    parameter int DEPTH = tlhd_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 operation,
    input  logic        [tlhd_pkg::LEVEL_W-1:0]  level_cm,
    input  logic        [tlhd_pkg::TIME_W-1:0]   time_ms,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [tlhd_pkg::WIN_W-1:0]    cfg_data,
    output logic                                 done,
    output logic signed [tlhd_pkg::OUT_W-1:0]    level_change_cm
);

    tlhd_pkg::dp_cmd_t    cmd;
    tlhd_pkg::dp_status_t status;
    logic                 cfg_we;

    // Accept configuration only between requests
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    tlhd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    tlhd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .level_cm        (level_cm),
        .time_ms         (time_ms),
        .level_change_cm (level_change_cm)
    );

endmodule

>>> sv/tlhd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tlhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, otherwise read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/tlhd_dp.sv
// Datapath of the level history: ring store, head and fill count, window
// register and the nearest-entry search. Uses tlhd_pkg and tlhd_ram.
`timescale 1ns / 1ps

module tlhd_dp #(
    parameter int DEPTH = tlhd_pkg::DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tlhd_pkg::dp_cmd_t                      cmd,
    output tlhd_pkg::dp_status_t                   status,
    input  logic                                   cfg_we,
    input  logic        [tlhd_pkg::WIN_W-1:0]      cfg_data,
    input  logic        [tlhd_pkg::LEVEL_W-1:0]    level_cm,
    input  logic        [tlhd_pkg::TIME_W-1:0]     time_ms,
    output logic signed [tlhd_pkg::OUT_W-1:0]      level_change_cm
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = tlhd_pkg::LEVEL_W + tlhd_pkg::TIME_W;

    logic        [IDX_W-1:0]             head_reg, head_next;
    logic        [CNT_W-1:0]             fill_reg, fill_next;
    logic        [tlhd_pkg::WIN_W-1:0]   window_reg, window_next;
    logic        [tlhd_pkg::TIME_W-1:0]  target_reg, target_next;
    logic        [tlhd_pkg::LEVEL_W-1:0] cur_level_reg, cur_level_next;
    logic        [IDX_W-1:0]             ptr_reg, ptr_next;
    logic        [CNT_W-1:0]             remain_reg, remain_next;
    logic        [tlhd_pkg::TIME_W-1:0]  best_dist_reg, best_dist_next;
    logic        [tlhd_pkg::LEVEL_W-1:0] best_level_reg, best_level_next;
    logic signed [tlhd_pkg::OUT_W-1:0]   result_reg, result_next;

    logic        [IDX_W-1:0]             head_prev;
    logic        [IDX_W-1:0]             ram_addr;
    logic        [WORD_W-1:0]            ram_wdata;
    logic        [WORD_W-1:0]            ram_rdata;
    logic        [tlhd_pkg::LEVEL_W-1:0] rd_level;
    logic        [tlhd_pkg::TIME_W-1:0]  rd_time;
    logic        [tlhd_pkg::TIME_W-1:0]  diff;
    logic        [tlhd_pkg::TIME_W-1:0]  distance;
    logic                                take;
    logic        [tlhd_pkg::LEVEL_W-1:0] sel_level;

    // Ring store: level in the upper bits, timestamp in the lower
    assign ram_addr  = cmd.push ? head_reg : ptr_reg;
    assign ram_wdata = {level_cm, time_ms};

    tlhd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_level = ram_rdata[WORD_W-1:tlhd_pkg::TIME_W];
    assign rd_time  = ram_rdata[tlhd_pkg::TIME_W-1:0];

    // Wrapped distance of the fetched entry to the target
    always_comb
    begin
        diff      = rd_time - target_reg;
        distance  = diff[tlhd_pkg::TIME_W-1] ? (~diff + 1'b1) : diff;
        take      = (distance < best_dist_reg);
        sel_level = take ? rd_level : best_level_reg;
    end

    // Newest entry sits just behind the head
    assign head_prev = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;

    // Next-value logic
    always_comb
    begin
        head_next       = head_reg;
        fill_next       = fill_reg;
        window_next     = window_reg;
        target_next     = target_reg;
        cur_level_next  = cur_level_reg;
        ptr_next        = ptr_reg;
        remain_next     = remain_reg;
        best_dist_next  = best_dist_reg;
        best_level_next = best_level_reg;
        result_next     = result_reg;

        // Take a configuration write
        if (cfg_we)
        begin
            window_next = cfg_data;
        end

        // Advance head and fill count on a push
        if (cmd.push)
        begin
            head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg != CNT_W'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        // Set up the walk for a query
        if (cmd.capture)
        begin
            target_next     = time_ms - {{(tlhd_pkg::TIME_W - tlhd_pkg::WIN_W){1'b0}},
                                         window_reg};
            cur_level_next  = level_cm;
            ptr_next        = head_prev;
            remain_next     = fill_reg;
            best_dist_next  = tlhd_pkg::NO_DISTANCE;
            best_level_next = '0;
            result_next     = '0;
        end

        // Step the read pointer back towards older entries
        if (cmd.issue_read)
        begin
            ptr_next    = (ptr_reg == '0) ? IDX_W'(DEPTH - 1) : ptr_reg - 1'b1;
            remain_next = remain_reg - 1'b1;
        end

        // Keep the first strictly nearer entry and refresh the answer
        if (cmd.compare)
        begin
            if (take)
            begin
                best_dist_next  = distance;
                best_level_next = rd_level;
            end
            result_next = $signed({1'b0, sel_level}) - $signed({1'b0, cur_level_reg});
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            window_reg <= tlhd_pkg::WINDOW_RESET;
            remain_reg <= '0;
            ptr_reg    <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            window_reg <= window_next;
            remain_reg <= remain_next;
            ptr_reg    <= ptr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        target_reg     <= target_next;
        cur_level_reg  <= cur_level_next;
        best_dist_reg  <= best_dist_next;
        best_level_reg <= best_level_next;
        result_reg     <= result_next;
    end

    // Status back to the controller
    assign status.fill_empty = (fill_reg == '0);
    assign status.more_left  = (remain_reg != '0);
    assign status.near_hit   = take && (distance < tlhd_pkg::NEAR_MS);

    assign level_change_cm = result_reg;

endmodule

>>> sv/tlhd_ctrl.sv
// Controller of the level history: sequences push, walk and response.
// Uses tlhd_pkg.
`timescale 1ns / 1ps

module tlhd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 operation,
    input  tlhd_pkg::dp_status_t status,
    output tlhd_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    tlhd_pkg::state_t state_reg, state_next;
    logic             accept;

    assign accept = start && (state_reg == tlhd_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlhd_pkg::ST_IDLE:
            begin
                if (accept && (operation == tlhd_pkg::OP_QUERY))
                begin
                    state_next = status.fill_empty ? tlhd_pkg::ST_RESPOND
                                                   : tlhd_pkg::ST_READ;
                end
            end
            tlhd_pkg::ST_READ:
            begin
                state_next = tlhd_pkg::ST_WALK;
            end
            tlhd_pkg::ST_WALK:
            begin
                if (status.near_hit || !status.more_left)
                begin
                    state_next = tlhd_pkg::ST_RESPOND;
                end
            end
            tlhd_pkg::ST_RESPOND:
            begin
                state_next = tlhd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tlhd_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd.push       = accept && (operation == tlhd_pkg::OP_PUSH);
        cmd.capture    = accept && (operation == tlhd_pkg::OP_QUERY);
        cmd.issue_read = 1'b0;
        cmd.compare    = 1'b0;
        busy           = 1'b1;
        done           = 1'b0;
        case (state_reg)
            tlhd_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            tlhd_pkg::ST_READ:
            begin
                cmd.issue_read = 1'b1;
            end
            tlhd_pkg::ST_WALK:
            begin
                cmd.compare    = 1'b1;
                cmd.issue_read = status.more_left && !status.near_hit;
            end
            tlhd_pkg::ST_RESPOND:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlhd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
